// ===== hw/rtl/bcp_pkg.sv =====
// Shared types, character codes and keyword tables of the bracketed command parser.
// No dependencies; every other file of the block imports this package.
package bcp_pkg;

   localparam int MAX_PACKET_CHARS = 99;
   localparam int TAG_COUNT        = 3;
   localparam int NAME_COUNT       = 2;

   localparam logic [7:0] CHAR_LBRACKET = 8'h5B;
   localparam logic [7:0] CHAR_RBRACKET = 8'h5D;
   localparam logic [7:0] CHAR_COMMA    = 8'h2C;
   localparam logic [7:0] CHAR_PLUS     = 8'h2B;
   localparam logic [7:0] CHAR_MINUS    = 8'h2D;
   localparam logic [7:0] CHAR_SPACE    = 8'h20;
   localparam logic [7:0] CHAR_ZERO     = 8'h30;
   localparam logic [7:0] CHAR_NINE     = 8'h39;
   localparam logic [7:0] CHAR_TAB      = 8'h09;
   localparam logic [7:0] CHAR_CR       = 8'h0D;

   localparam logic [1:0] KIND_TASK       = 2'd0;
   localparam logic [1:0] KIND_MISSING_ID = 2'd1;
   localparam logic [1:0] KIND_JOYSTICK   = 2'd2;

   localparam logic [1:0] PHASE_SKIP   = 2'd0;
   localparam logic [1:0] PHASE_DIGITS = 2'd1;
   localparam logic [1:0] PHASE_DONE   = 2'd2;

   localparam logic REG_TASK_ID_MIN = 1'b0;
   localparam logic REG_TASK_ID_MAX = 1'b1;

   localparam logic [16:0] NUM_LIMIT = 17'd32768;

   localparam logic [7:0] TAG_WORDS [0:2][0:7] = '{
      '{8'h74, 8'h61, 8'h73, 8'h6B, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h73, 8'h6C, 8'h69, 8'h64, 8'h65, 8'h72, 8'h00, 8'h00},
      '{8'h6A, 8'h6F, 8'h79, 8'h73, 8'h74, 8'h69, 8'h63, 8'h6B}
   };
   localparam logic [3:0] TAG_LENS [0:2] = '{4'd4, 4'd6, 4'd8};
   localparam logic [7:0] NAME_WORDS [0:1][0:3] = '{
      '{8'h74, 8'h61, 8'h73, 8'h6B},
      '{8'h54, 8'h61, 8'h73, 8'h6B}
   };
   localparam logic [3:0] NAME_LEN = 4'd4;

   typedef struct packed {
      logic [16:0] accum;
      logic        negative;
      logic [1:0]  phase;
   } num_state_type;

   function automatic logic tag_char_match(input logic [1:0] sel, input logic [3:0] pos,
                                           input logic [7:0] ch);
      logic hit;
      hit = 1'b0;
      if (pos < TAG_LENS[sel]) hit = (TAG_WORDS[sel][pos[2:0]] == ch);
      return hit;
   endfunction

   function automatic logic name_char_match(input logic sel, input logic [3:0] pos,
                                            input logic [7:0] ch);
      logic hit;
      hit = 1'b0;
      if (pos < NAME_LEN) hit = (NAME_WORDS[sel][pos[1:0]] == ch);
      return hit;
   endfunction

endpackage

// ===== hw/rtl/bracketed_command_parser.sv =====
// Top level of the bracketed command parser: byte stream in, command beats out,
// APB-style range registers. Depends on bcp_pkg and bcp_atoi.
//
// The block takes one received byte per clock cycle when not stalled and frames packets
// from '[' to ']'; a packet longer than 99 characters is dropped. On the ']' byte it
// emits at most one command beat, registered in the cycle after that byte is accepted.
// All per-byte work is one pass of logic into the parser state and the output register,
// so req_tready is low only while a command beat is held and rsp_tready is low.
module bracketed_command_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // [7:0] task_id, [8] task_id_ok, [24:9] speed_value,
                                    // [40:25] turn_value, [47:41] zero
   output logic [1:0]  rsp_tuser,   // [1:0] cmd_kind
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import bcp_pkg::*;

   logic [7:0]    id_min_ff, id_max_ff;
   logic          in_packet_ff, in_packet_in;
   logic [6:0]    char_count_ff, char_count_in;
   logic [2:0]    token_number_ff, token_number_in;
   logic [3:0]    token_pos_ff, token_pos_in;
   logic [2:0]    tag_ff, tag_in;
   logic [1:0]    name_ff, name_in;
   num_state_type num_ff, num_in, num_fed;
   logic [15:0]   first_ff, first_in;
   logic [15:0]   speed_ff, speed_in;
   logic [15:0]   turn_ff, turn_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [1:0]    kind_ff, kind_in;
   logic [7:0]    id_ff, id_in;
   logic          ok_ff, ok_in;
   logic [15:0]   rsp_speed_ff, rsp_speed_in;
   logic [15:0]   rsp_turn_ff, rsp_turn_in;

   logic          accept;
   logic          csr_write;
   logic [7:0]    c;
   logic [15:0]   num_value;
   logic          new_token;
   logic [2:0]    tn_body, idx_body, idx_end;
   logic [2:0]    te_tag;
   logic [1:0]    te_name;
   logic [15:0]   te_first, te_speed, te_turn;
   logic [7:0]    cmd_id;

   assign c          = req_tdata;
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign new_token  = (token_pos_ff == 4'd0);

   bcp_atoi u_atoi (
      .restart   (new_token),
      .rx_char   (c),
      .num_state (num_ff),
      .num_next  (num_fed),
      .num_value (num_value)
   );

   always_comb begin
      te_tag   = tag_ff;
      te_name  = name_ff;
      te_first = first_ff;
      te_speed = speed_ff;
      te_turn  = turn_ff;
      idx_end  = token_number_ff - 3'd1;
      if (!new_token) begin
         if (idx_end == 3'd0) begin
            for (int i = 0; i < TAG_COUNT; i++) begin
               if (TAG_LENS[i] != token_pos_ff) te_tag[i] = 1'b0;
            end
         end else if (idx_end == 3'd1) begin
            if (token_pos_ff != NAME_LEN) te_name = 2'b00;
         end
         if (te_tag[0] && (idx_end == 3'd1)) te_first = num_value;
         if (te_tag[1] && (idx_end == 3'd2)) te_first = num_value;
         if (te_tag[2] && (idx_end == 3'd2)) te_speed = num_value;
         if (te_tag[2] && (idx_end == 3'd3)) te_turn = num_value;
      end
   end

   always_comb begin
      tn_body  = token_number_ff;
      if (new_token && (token_number_ff < 3'd7)) tn_body = token_number_ff + 3'd1;
      idx_body = tn_body - 3'd1;
   end

   always_comb begin
      in_packet_in    = in_packet_ff;
      char_count_in   = char_count_ff;
      token_number_in = token_number_ff;
      token_pos_in    = token_pos_ff;
      tag_in          = tag_ff;
      name_in         = name_ff;
      num_in          = num_ff;
      first_in        = first_ff;
      speed_in        = speed_ff;
      turn_in         = turn_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_tready;
      kind_in         = kind_ff;
      id_in           = id_ff;
      ok_in           = ok_ff;
      rsp_speed_in    = rsp_speed_ff;
      rsp_turn_in     = rsp_turn_ff;
      cmd_id          = te_first[7:0];

      if (accept) begin
         if (!in_packet_ff) begin
            if (c == CHAR_LBRACKET) begin
               in_packet_in    = 1'b1;
               char_count_in   = 7'd0;
               token_number_in = 3'd0;
               token_pos_in    = 4'd0;
               tag_in          = 3'b111;
               name_in         = 2'b11;
               num_in          = '{accum: '0, negative: 1'b0, phase: PHASE_SKIP};
            end
         end else if (c != CHAR_RBRACKET) begin
            if (char_count_ff < 7'(MAX_PACKET_CHARS)) begin
               char_count_in = char_count_ff + 7'd1;
               if (c == CHAR_COMMA) begin
                  tag_in       = te_tag;
                  name_in      = te_name;
                  first_in     = te_first;
                  speed_in     = te_speed;
                  turn_in      = te_turn;
                  token_pos_in = 4'd0;
               end else begin
                  token_number_in = tn_body;
                  if (idx_body == 3'd0) begin
                     for (int i = 0; i < TAG_COUNT; i++) begin
                        if (!tag_char_match(2'(i), token_pos_ff, c)) tag_in[i] = 1'b0;
                     end
                  end else if (idx_body == 3'd1) begin
                     for (int i = 0; i < NAME_COUNT; i++) begin
                        if (!name_char_match(1'(i), token_pos_ff, c)) name_in[i] = 1'b0;
                     end
                  end
                  num_in = num_fed;
                  if (token_pos_ff < 4'd15) token_pos_in = token_pos_ff + 4'd1;
               end
            end else begin
               in_packet_in    = 1'b0;
               char_count_in   = 7'd0;
               token_number_in = 3'd0;
               token_pos_in    = 4'd0;
               tag_in          = 3'b111;
               name_in         = 2'b11;
               num_in          = '{accum: '0, negative: 1'b0, phase: PHASE_SKIP};
            end
         end else begin
            in_packet_in = 1'b0;
            tag_in       = te_tag;
            name_in      = te_name;
            first_in     = te_first;
            speed_in     = te_speed;
            turn_in      = te_turn;
            token_pos_in = 4'd0;
            rsp_valid_in = 1'b0;
            kind_in      = KIND_TASK;
            id_in        = 8'd0;
            ok_in        = 1'b0;
            rsp_speed_in = 16'd0;
            rsp_turn_in  = 16'd0;
            if ((token_number_ff >= 3'd1) && te_tag[0]) begin
               rsp_valid_in = 1'b1;
               if (token_number_ff < 3'd2) begin
                  kind_in = KIND_MISSING_ID;
               end else begin
                  id_in = cmd_id;
                  ok_in = (cmd_id >= id_min_ff) && (cmd_id <= id_max_ff);
               end
            end else if ((token_number_ff >= 3'd3) && te_tag[1] && (te_name != 2'b00)) begin
               rsp_valid_in = 1'b1;
               id_in        = cmd_id;
               ok_in        = (cmd_id >= id_min_ff) && (cmd_id <= id_max_ff);
            end else if ((token_number_ff >= 3'd5) && te_tag[2]) begin
               rsp_valid_in = 1'b1;
               kind_in      = KIND_JOYSTICK;
               rsp_speed_in = te_speed;
               rsp_turn_in  = te_turn;
            end
         end
      end
   end

   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;
   assign csr_prdata = {24'd0, (csr_paddr[2] == REG_TASK_ID_MAX) ? id_max_ff : id_min_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         id_min_ff       <= 8'd1;
         id_max_ff       <= 8'd5;
         in_packet_ff    <= 1'b0;
         char_count_ff   <= 7'd0;
         token_number_ff <= 3'd0;
         token_pos_ff    <= 4'd0;
         tag_ff          <= 3'b111;
         name_ff         <= 2'b11;
         num_ff          <= '{accum: '0, negative: 1'b0, phase: PHASE_SKIP};
         first_ff        <= 16'd0;
         speed_ff        <= 16'd0;
         turn_ff         <= 16'd0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (csr_write && (csr_paddr[2] == REG_TASK_ID_MIN)) id_min_ff <= csr_pwdata[7:0];
         if (csr_write && (csr_paddr[2] == REG_TASK_ID_MAX)) id_max_ff <= csr_pwdata[7:0];
         in_packet_ff    <= in_packet_in;
         char_count_ff   <= char_count_in;
         token_number_ff <= token_number_in;
         token_pos_ff    <= token_pos_in;
         tag_ff          <= tag_in;
         name_ff         <= name_in;
         num_ff          <= num_in;
         first_ff        <= first_in;
         speed_ff        <= speed_in;
         turn_ff         <= turn_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff      <= kind_in;
      id_ff        <= id_in;
      ok_ff        <= ok_in;
      rsp_speed_ff <= rsp_speed_in;
      rsp_turn_ff  <= rsp_turn_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = kind_ff;
   assign rsp_tdata  = {7'd0, rsp_turn_ff, rsp_speed_ff, ok_ff, id_ff};

   a_non_joystick_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (kind_ff != KIND_JOYSTICK) |-> (rsp_speed_ff == 16'd0)
                                                  && (rsp_turn_ff == 16'd0))
      else $error("non-joystick beat carries joystick values");

   a_missing_id_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (kind_ff == KIND_MISSING_ID) |-> (id_ff == 8'd0) && !ok_ff)
      else $error("missing-id beat carries an id");

   a_char_count_bound: assert property (@(posedge clock) disable iff (reset)
      char_count_ff <= 7'(MAX_PACKET_CHARS))
      else $error("packet character count beyond limit");

   a_no_beat_outside_packet: assert property (@(posedge clock) disable iff (reset)
      accept && !in_packet_ff |=> !$rose(rsp_valid_ff))
      else $error("beat produced by a byte outside a packet");

   a_beat_only_on_close: assert property (@(posedge clock) disable iff (reset)
      accept && (c != CHAR_RBRACKET) |=> !$rose(rsp_valid_ff))
      else $error("beat produced by a byte other than the closing bracket");

endmodule

// ===== hw/rtl/bcp_atoi.sv =====
// Decimal number reader of the bracketed command parser: next accumulator state
// for one token character and the saturated 16-bit value. Depends on bcp_pkg.
module bcp_atoi (
   input  logic                   restart,
   input  logic [7:0]             rx_char,
   input  bcp_pkg::num_state_type num_state,
   output bcp_pkg::num_state_type num_next,
   output logic [15:0]            num_value
);
   import bcp_pkg::*;

   num_state_type base;
   logic          is_digit;
   logic          is_blank;
   logic [18:0]   grown;
   logic [16:0]   accum_digit;

   always_comb begin
      base     = restart ? num_state_type'{accum: '0, negative: 1'b0, phase: PHASE_SKIP}
                         : num_state;
      is_digit = (rx_char >= CHAR_ZERO) && (rx_char <= CHAR_NINE);
      is_blank = (rx_char == CHAR_SPACE) || ((rx_char >= CHAR_TAB) && (rx_char <= CHAR_CR));
      grown    = ({2'b00, base.accum} << 3) + ({2'b00, base.accum} << 1)
                 + {15'd0, rx_char[3:0]};
      accum_digit = (grown > {2'b00, NUM_LIMIT}) ? NUM_LIMIT : grown[16:0];

      num_next = base;
      case (base.phase)
         PHASE_SKIP: begin
            if (is_blank) begin
               num_next = base;
            end else if ((rx_char == CHAR_PLUS) || (rx_char == CHAR_MINUS)) begin
               num_next.negative = (rx_char == CHAR_MINUS);
               num_next.phase    = PHASE_DIGITS;
            end else if (is_digit) begin
               num_next.phase = PHASE_DIGITS;
               num_next.accum = accum_digit;
            end else begin
               num_next.phase = PHASE_DONE;
            end
         end
         PHASE_DIGITS: begin
            if (is_digit) num_next.accum = accum_digit;
            else num_next.phase = PHASE_DONE;
         end
         default: num_next = base;
      endcase

      if (num_state.negative) begin
         num_value = 16'(17'd0 - num_state.accum);
      end else if (num_state.accum > 17'd32767) begin
         num_value = 16'h7FFF;
      end else begin
         num_value = num_state.accum[15:0];
      end
   end

endmodule

// ===== tb/bcp_command_check_pkg.sv =====
// Command predictor and scoreboard for the bracketed command parser test.
// Depends on bcp_pkg for the character codes, keyword tables and command kinds.
package bcp_command_check_pkg;
   import bcp_pkg::*;

   localparam int TAG_TASK        = 0;
   localparam int TAG_SLIDER      = 1;
   localparam int TAG_JOYSTICK    = 2;
   localparam int TOKEN_LIMIT     = 7;
   localparam int TOKEN_POS_LIMIT = 15;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  id;
      logic        ok;
      logic [15:0] speed;
      logic [15:0] turn;
   } command_type;

   class command_tracker;
      command_type pending [$];
      int          errors;
      int          bytes_used;
      int          beats_checked;
      logic [7:0]  id_lo;
      logic [7:0]  id_hi;
      bit          open_packet;
      int          stored_chars;
      int          tokens_seen;
      int          token_chars;
      logic [2:0]  tag_hits;
      logic [1:0]  name_hits;
      int          magnitude;
      bit          minus;
      logic [1:0]  scan;
      logic [15:0] id_word;
      logic [15:0] speed_word;
      logic [15:0] turn_word;

      function new();
         errors = 0;
         bytes_used = 0;
         beats_checked = 0;
         id_lo = 8'd1;
         id_hi = 8'd5;
         open_packet = 1'b0;
         id_word = '0;
         speed_word = '0;
         turn_word = '0;
         start_packet();
      endfunction

      function void clear_scan();
         magnitude = 0;
         minus = 1'b0;
         scan = PHASE_SKIP;
      endfunction

      function void start_packet();
         stored_chars = 0;
         tokens_seen = 0;
         token_chars = 0;
         tag_hits = '1;
         name_hits = '1;
         clear_scan();
      endfunction

      function logic [15:0] scan_value();
         if (minus) return 16'(-magnitude);
         return (magnitude > 32767) ? 16'd32767 : 16'(magnitude);
      endfunction

      function void finish_token();
         int slot;
         if (token_chars == 0) return;
         slot = tokens_seen - 1;
         if (slot == 0) begin
            for (int i = 0; i < TAG_COUNT; i++)
               if (TAG_LENS[i] != token_chars) tag_hits[i] = 1'b0;
         end else if (slot == 1 && token_chars != NAME_LEN) begin
            name_hits = '0;
         end
         if (tag_hits[TAG_TASK] && slot == 1) id_word = scan_value();
         if (tag_hits[TAG_SLIDER] && slot == 2) id_word = scan_value();
         if (tag_hits[TAG_JOYSTICK] && slot == 2) speed_word = scan_value();
         if (tag_hits[TAG_JOYSTICK] && slot == 3) turn_word = scan_value();
         token_chars = 0;
      endfunction

      function void set_limit(logic idx, logic [7:0] value);
         if (idx == REG_TASK_ID_MIN) id_lo = value;
         else id_hi = value;
      endfunction

      function void note_byte(logic [7:0] c);
         int slot;
         bit signed_now;
         bit blank;
         bit fires;
         bit with_id;
         command_type want;
         if (!open_packet) begin
            if (c == CHAR_LBRACKET) begin
               open_packet = 1'b1;
               start_packet();
               bytes_used++;
            end
            return;
         end
         bytes_used++;
         if (c != CHAR_RBRACKET) begin
            if (stored_chars >= MAX_PACKET_CHARS) begin
               open_packet = 1'b0;
               start_packet();
            end else if (c == CHAR_COMMA) begin
               stored_chars++;
               finish_token();
            end else begin
               stored_chars++;
               if (token_chars == 0) begin
                  if (tokens_seen < TOKEN_LIMIT) tokens_seen++;
                  clear_scan();
               end
               slot = tokens_seen - 1;
               for (int i = 0; i < TAG_COUNT; i++)
                  if (slot == 0 && (token_chars >= TAG_LENS[i] ||
                                    TAG_WORDS[i][token_chars] != c))
                     tag_hits[i] = 1'b0;
               for (int i = 0; i < NAME_COUNT; i++)
                  if (slot == 1 && (token_chars >= NAME_LEN ||
                                    NAME_WORDS[i][token_chars] != c))
                     name_hits[i] = 1'b0;
               blank = (c == CHAR_SPACE) || (c >= CHAR_TAB && c <= CHAR_CR);
               signed_now = 1'b0;
               if (scan == PHASE_SKIP && !blank) begin
                  scan = PHASE_DIGITS;
                  if (c == CHAR_PLUS || c == CHAR_MINUS) begin
                     minus = (c == CHAR_MINUS);
                     signed_now = 1'b1;
                  end
               end
               if (scan == PHASE_DIGITS && !signed_now) begin
                  if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
                     magnitude = magnitude * 10 + int'(c - CHAR_ZERO);
                     if (magnitude > NUM_LIMIT) magnitude = NUM_LIMIT;
                  end else begin
                     scan = PHASE_DONE;
                  end
               end
               if (token_chars < TOKEN_POS_LIMIT) token_chars++;
            end
            return;
         end
         open_packet = 1'b0;
         finish_token();
         want = '0;
         fires = 1'b0;
         with_id = 1'b0;
         if (tokens_seen >= 1 && tag_hits[TAG_TASK]) begin
            fires = 1'b1;
            if (tokens_seen < 2) want.kind = KIND_MISSING_ID;
            else with_id = 1'b1;
         end else if (tokens_seen >= 3 && tag_hits[TAG_SLIDER] && name_hits != 0) begin
            fires = 1'b1;
            with_id = 1'b1;
         end else if (tokens_seen >= 5 && tag_hits[TAG_JOYSTICK]) begin
            fires = 1'b1;
            want.kind = KIND_JOYSTICK;
            want.speed = speed_word;
            want.turn = turn_word;
         end
         if (with_id) begin
            want.kind = KIND_TASK;
            want.id = id_word[7:0];
            want.ok = (want.id >= id_lo) && (want.id <= id_hi);
         end
         if (fires) pending.push_back(want);
      endfunction

      task report_mismatch(string msg);
         $display("MISMATCH %s", msg);
         errors++;
      endtask

      task check_beat(logic [47:0] data, logic [1:0] kind);
         command_type want;
         beats_checked++;
         if (pending.size() == 0) begin
            report_mismatch($sformatf("beat %0d: no command expected, got kind %0d data %h",
                                      beats_checked, kind, data));
            return;
         end
         want = pending.pop_front();
         if (kind !== want.kind)
            report_mismatch($sformatf("beat %0d: cmd_kind %0d, expected %0d",
                                      beats_checked, kind, want.kind));
         if (data[7:0] !== want.id)
            report_mismatch($sformatf("beat %0d: task_id %0d, expected %0d",
                                      beats_checked, data[7:0], want.id));
         if (data[8] !== want.ok)
            report_mismatch($sformatf("beat %0d: task_id_ok %b, expected %b",
                                      beats_checked, data[8], want.ok));
         if (data[24:9] !== want.speed)
            report_mismatch($sformatf("beat %0d: speed_value %h, expected %h",
                                      beats_checked, data[24:9], want.speed));
         if (data[40:25] !== want.turn)
            report_mismatch($sformatf("beat %0d: turn_value %h, expected %h",
                                      beats_checked, data[40:25], want.turn));
      endtask
   endclass

endpackage

// ===== tb/bracketed_command_parser_test.sv =====
// Top-level test of the bracketed command parser: directed and random byte streams,
// random idling on both streams and range register changes. Depends on bcp_pkg and
// bcp_command_check_pkg.
module bracketed_command_parser_test;
   timeunit 1ns;
   timeprecision 1ps;
   import bcp_pkg::*;
   import bcp_command_check_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   command_tracker sb = new();
   logic [7:0]     burst [$];

   string slider_names [6] = '{"task", "Task", "task", "Task", "tasks", "tAsk"};
   string near_tags [8] = '{"Task", "tas", "taskk", "slide", "Slider", "joystic",
                            "joystickk", "jOystick"};
   string directed_text [$] = '{
      "[task,3]", "[task]", "[task,,,0]", "[,task,,4,]", "[task ,3]", "[slider,task,5]",
      "[slider,Task,261]", "[slider,tusk,2]", "[slider,task]", "[joystick,1,-200,300,4]",
      "[joystick,1,2,3]", "[joystick, 9,\t+32767,-32768,0,77]", "[task, 99999]",
      "[task,-99999]", "[task,-1]", "[task,12ab]", "[Task,3]", "[]", "zq]x[task,4]",
      "[[task,2]", "[joystick,a,b,c,d]"
   };

   bracketed_command_parser DUT (.*);

   initial begin
      forever #10 clock = ~clock;
   end

   initial begin
      #5ms;
      $display("bracketed_command_parser test failed");
      $finish;
   end

   function automatic void add_text(string s);
      for (int i = 0; i < s.len(); i++) burst.push_back(s[i]);
   endfunction

   function automatic void add_sep();
      burst.push_back(CHAR_COMMA);
      if ($urandom_range(7) == 0) burst.push_back(CHAR_COMMA);
   endfunction

   function automatic void add_number();
      int shape;
      int digits;
      shape = $urandom_range(19);
      while ($urandom_range(7) == 0) burst.push_back($urandom_range(1) ? CHAR_SPACE : CHAR_TAB);
      case ($urandom_range(7))
         0: burst.push_back(CHAR_MINUS);
         1: burst.push_back(CHAR_PLUS);
         default: ;
      endcase
      if (shape < 12) digits = 1;
      else if (shape < 16) digits = $urandom_range(2, 3);
      else if (shape < 19) digits = $urandom_range(4, 7);
      else digits = 0;
      repeat (digits) burst.push_back(8'(CHAR_ZERO + $urandom_range(9)));
      if ($urandom_range(11) == 0) burst.push_back(8'($urandom_range(33, 126)));
   endfunction

   function automatic void add_random_packet();
      int pick;
      logic [7:0] fill;
      pick = $urandom_range(99);
      if ($urandom_range(7) == 0)
         repeat ($urandom_range(1, 3)) burst.push_back(8'($urandom_range(255)));
      burst.push_back(CHAR_LBRACKET);
      if ($urandom_range(11) == 0) burst.push_back(CHAR_COMMA);
      if (pick < 25) begin
         add_text("task");
         if ($urandom_range(7) != 0) begin
            add_sep();
            add_number();
         end
      end else if (pick < 45) begin
         add_text("slider");
         add_sep();
         add_text(slider_names[$urandom_range(5)]);
         if ($urandom_range(7) != 0) begin
            add_sep();
            add_number();
         end
      end else if (pick < 70) begin
         add_text("joystick");
         repeat ($urandom_range(3, 5)) begin
            add_sep();
            add_number();
         end
      end else if (pick < 82) begin
         add_text(near_tags[$urandom_range(7)]);
         repeat ($urandom_range(4)) begin
            add_sep();
            add_number();
         end
      end else if (pick < 95) begin
         repeat ($urandom_range(12)) burst.push_back(8'($urandom_range(255)));
      end else begin
         add_text("task,1,");
         repeat ($urandom_range(88, 96)) begin
            do fill = 8'($urandom_range(255)); while (fill == CHAR_RBRACKET);
            burst.push_back(fill);
         end
      end
      if ($urandom_range(9) == 0) begin
         add_sep();
         add_number();
      end
      if ($urandom_range(24) != 0) burst.push_back(CHAR_RBRACKET);
   endfunction

   task send_burst();
      foreach (burst[i]) begin
         if (sb.bytes_used < 900 || sb.bytes_used >= 1300) begin
            while ($urandom_range(99) < 38) begin
               req_tvalid <= 1'b0;
               @(posedge clock);
            end
         end
         req_tvalid <= 1'b1;
         req_tdata <= burst[i];
         do @(posedge clock); while (req_tready !== 1'b1);
         sb.note_byte(burst[i]);
      end
      burst.delete();
   endtask

   task drain();
      int waited;
      waited = 0;
      req_tvalid <= 1'b0;
      while (sb.pending.size() != 0 && waited < 5000) begin
         @(posedge clock);
         waited++;
      end
      if (sb.pending.size() != 0) begin
         sb.report_mismatch($sformatf("%0d command beats never arrived", sb.pending.size()));
         sb.pending.delete();
      end
      repeat (4) @(posedge clock);
   endtask

   task csr_write(input logic idx, input logic [7:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= {24'h0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      sb.set_limit(idx, value);
      @(posedge clock);
   endtask

   initial begin
      int hold_left = 0;
      bit held = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid === 1'b1 && rsp_tready) begin
            sb.check_beat(rsp_tdata, rsp_tuser);
         end
         if (!held && sb.bytes_used >= 700) begin
            held = 1'b1;
            hold_left = 300;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (sb.bytes_used >= 1000 && sb.bytes_used < 1400) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= ($urandom_range(99) >= 38);
         end
      end
   end

   initial begin
      int lo;
      int hi;
      int target;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_text[i]) add_text(directed_text[i]);
      add_text("[task,2");
      burst.push_back(8'h00);
      add_text("]");
      add_text("[task,");
      burst.push_back(CHAR_CR);
      burst.push_back(CHAR_TAB);
      add_text(" 4]");
      add_text("[task,");
      burst.push_back(8'hFF);
      add_text("5]");
      add_text("[task,1,");
      repeat (92) burst.push_back(8'(CHAR_ZERO + 7));
      add_text("x][task,4]");
      add_text("[joystick,1,2,3,4,");
      repeat (82) burst.push_back(CHAR_COMMA);
      burst.push_back(CHAR_RBRACKET);
      send_burst();
      drain();

      for (int seg = 0; seg < 8; seg++) begin
         case (seg)
            0: begin lo = 0; hi = 255; end
            1: begin lo = 255; hi = 0; end
            2: begin lo = 0; hi = 0; end
            3: begin lo = 255; hi = 255; end
            4: begin lo = 7; hi = 7; end
            5, 6: begin lo = $urandom_range(255); hi = $urandom_range(255); end
            default: begin lo = 1; hi = 5; end
         endcase
         csr_write(REG_TASK_ID_MIN, 8'(lo));
         csr_write(REG_TASK_ID_MAX, 8'(hi));
         target = sb.bytes_used + 160;
         while (sb.bytes_used < target) begin
            add_random_packet();
            send_burst();
         end
         drain();
      end

      repeat (20) @(posedge clock);
      if (sb.errors == 0) $display("bracketed_command_parser test passed");
      else $display("bracketed_command_parser test failed");
      $finish;
   end

endmodule

// ===== bracketed_command_parser.f =====
hw/rtl/bcp_pkg.sv
hw/rtl/bcp_atoi.sv
hw/rtl/bracketed_command_parser.sv
tb/bcp_command_check_pkg.sv
tb/bracketed_command_parser_test.sv
